@@ rtl/npc_pkg.sv @@
// Shared types, constants and the byte-distance function for the
// nearest palette color block. No dependencies.
`timescale 1ns / 1ps

package npc_pkg;

   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int INDEX_SPAN            = 256;
   localparam int COUNT_W               = 9;
   localparam int INDEX_W               = 8;
   localparam int COLOR_W               = 32;
   localparam int DIST_W                = 10;
   localparam int BEST_W                = 16;

   localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 32'h6633_99ff;
   localparam logic [BEST_W-1:0]  NO_DISTANCE   = 16'hffff;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_MAP  = 1'b1;

   // One word in flight down the chain, with the best match found so far.
   typedef struct packed {
      logic                valid;
      logic                func;
      logic [INDEX_W-1:0]  entry_index;
      logic [COLOR_W-1:0]  color_word;
      logic [BEST_W-1:0]   best_dist;
      logic [COLOR_W-1:0]  best_color;
      logic [INDEX_W-1:0]  best_at;
   } stage_type;

   function automatic logic [DIST_W-1:0] manhattan(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      logic [7:0]        x;
      logic [7:0]        y;
      logic [DIST_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < 4; i++) begin
         x = a[i*8 +: 8];
         y = b[i*8 +: 8];
         sum = sum + ((x > y) ? DIST_W'(x - y) : DIST_W'(y - x));
      end
      return sum;
   endfunction

endpackage

@@ rtl/nearest_palette_color_l1.sv @@
// Top level of the nearest palette color block: count register, the chain of
// palette cells and the result register. Depends on npc_pkg and npc_cell.
//
//   channel   ports                                   handshake
//   request   req_func, req_entry_index, req_color_word   start / busy
//   response  rsp_mapped_color, rsp_best_index,           rsp_strobe
//             rsp_best_distance, rsp_no_entry
//   config    csr_write_data                          csr_write_en
//
// One word enters per cycle; busy stays low. Loads and maps travel the same
// chain of PALETTE_DEPTH cells, one cell per cycle, so order is kept.
// A map result passes through the register of every cell and then the result
// register before it is on the result ports.
// Synchronous reset clears the count and the chain valid bits; palette
// entries hold no reset value. The receiver cannot stall the result.
`timescale 1ns / 1ps

module nearest_palette_color_l1
   import npc_pkg::*;
#(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [COLOR_W-1:0]  req_color_word,
   output logic                rsp_strobe,
   output logic [COLOR_W-1:0]  rsp_mapped_color,
   output logic [INDEX_W-1:0]  rsp_best_index,
   output logic [DIST_W-1:0]   rsp_best_distance,
   output logic                rsp_no_entry,
   input  logic                csr_write_en,
   input  logic [COUNT_W-1:0]  csr_write_data
);

   localparam int LIMIT = (PALETTE_DEPTH < INDEX_SPAN) ? PALETTE_DEPTH : INDEX_SPAN;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] active_count;
   stage_type          chain [PALETTE_DEPTH+1];
   stage_type          tail;

   logic               strobe_ff, strobe_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic               none_ff, none_in;
   logic               none_found;

   assign busy = 1'b0;

   assign count_in     = csr_write_en ? csr_write_data : count_ff;
   assign active_count = (count_ff > COUNT_W'(LIMIT)) ? COUNT_W'(LIMIT) : count_ff;

   always_comb begin
      chain[0].valid       = start && !busy;
      chain[0].func        = req_func;
      chain[0].entry_index = req_entry_index;
      chain[0].color_word  = req_color_word;
      chain[0].best_dist   = NO_DISTANCE;
      chain[0].best_color  = DEFAULT_COLOR;
      chain[0].best_at     = '0;
   end

   for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
      npc_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .active_count (active_count),
         .stage_in     (chain[k]),
         .stage_out    (chain[k+1])
      );
   end

   assign tail       = chain[PALETTE_DEPTH];
   assign none_found = (tail.best_dist == NO_DISTANCE);

   always_comb begin
      strobe_in = tail.valid && (tail.func == FUNC_MAP);
      color_in  = tail.best_color;
      index_in  = tail.best_at;
      none_in   = none_found;
      // an empty search leaves the default color and reports zero distance
      dist_in   = none_found ? '0 : tail.best_dist[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      color_ff <= color_in;
      index_ff <= index_in;
      dist_ff  <= dist_in;
      none_ff  <= none_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_mapped_color  = color_ff;
   assign rsp_best_index    = index_ff;
   assign rsp_best_distance = dist_ff;
   assign rsp_no_entry      = none_ff;

endmodule

@@ rtl/npc_cell.sv @@
// One palette cell: holds one entry, compares the passing pixel against it
// and hands the word on to the next cell. Depends on npc_pkg.
`timescale 1ns / 1ps

module npc_cell
   import npc_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [COUNT_W-1:0]  active_count,
   input  stage_type           stage_in,
   output stage_type           stage_out
);

   logic [COLOR_W-1:0] entry_ff;
   logic [COLOR_W-1:0] entry_in;
   stage_type          stage_ff;
   stage_type          stage_in_next;
   logic [DIST_W-1:0]  gap;
   logic               hit_load;
   logic               active;

   assign gap      = manhattan(stage_in.color_word, entry_ff);
   assign hit_load = stage_in.valid && (stage_in.func == FUNC_LOAD)
                     && ({24'd0, stage_in.entry_index} == 32'(CELL_INDEX));
   assign active   = {23'd0, active_count} > 32'(CELL_INDEX);

   always_comb begin
      entry_in      = hit_load ? stage_in.color_word : entry_ff;
      stage_in_next = stage_in;
      // take this entry on a strictly smaller distance; lower index wins a tie
      if (stage_in.valid && (stage_in.func == FUNC_MAP) && active
          && ({6'd0, gap} < stage_in.best_dist)) begin
         stage_in_next.best_dist  = {6'd0, gap};
         stage_in_next.best_color = entry_ff;
         stage_in_next.best_at    = INDEX_W'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;

endmodule

@@ rtl/npc_checker.sv @@
// Port-level checks for the nearest palette color block, bound to the top
// level. Depends on npc_pkg.
`timescale 1ns / 1ps

module npc_checker
   import npc_pkg::*;
#(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                req_func,
   input logic                rsp_strobe,
   input logic [COLOR_W-1:0]  rsp_mapped_color,
   input logic [INDEX_W-1:0]  rsp_best_index,
   input logic [DIST_W-1:0]   rsp_best_distance,
   input logic                rsp_no_entry
);

   localparam int LATENCY = PALETTE_DEPTH + 1;

   // every result traces back to a map word taken a fixed time earlier
   a_result_has_map: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && (req_func == FUNC_MAP), LATENCY))
      else $error("result without a matching map word");

   // a map word always yields a result after the chain latency
   a_map_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == FUNC_MAP)) |-> ##LATENCY rsp_strobe)
      else $error("map word lost in the chain");

   a_default_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_no_entry) |->
         (rsp_mapped_color == DEFAULT_COLOR) && (rsp_best_index == '0)
         && (rsp_best_distance == '0))
      else $error("empty palette result malformed");

   a_distance_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_best_distance <= DIST_W'(1020)))
      else $error("distance out of range");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe after reset");

endmodule

bind nearest_palette_color_l1 npc_checker #(
   .PALETTE_DEPTH (PALETTE_DEPTH)
) u_npc_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_func          (req_func),
   .rsp_strobe        (rsp_strobe),
   .rsp_mapped_color  (rsp_mapped_color),
   .rsp_best_index    (rsp_best_index),
   .rsp_best_distance (rsp_best_distance),
   .rsp_no_entry      (rsp_no_entry)
);

@@ verif/tb_nearest_palette_color_l1.sv @@
// Self-checking testbench for nearest_palette_color_l1: directed table, then random phases
// over several palette counts, each map checked against the table or a behavioral nearest-entry search.
// Depends on npc_pkg and the nearest_palette_color_l1 RTL.
`timescale 1ns / 1ps

module tb_nearest_palette_color_l1;
   import npc_pkg::*;

   localparam int CHAIN_LATENCY = PALETTE_DEPTH_DEFAULT + 1;
   localparam int DRAIN_CYCLES  = CHAIN_LATENCY + 8;
   localparam int STALL_LIMIT   = 4 * DRAIN_CYCLES;
   localparam int SEARCH_SPAN   = (PALETTE_DEPTH_DEFAULT < INDEX_SPAN) ?
                                  PALETTE_DEPTH_DEFAULT : INDEX_SPAN;
   localparam int PHASE_WORDS   = 150;
   localparam int RANDOM_PHASES = 10;
   localparam int COUNT_MAX     = (1 << COUNT_W) - 1;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [INDEX_W-1:0] index;
      logic [DIST_W-1:0]  distance;
      logic               no_entry;
   } match_type;

   typedef enum logic [1:0] {STEP_COUNT, STEP_LOAD, STEP_MAP, STEP_MAP_KNOWN} step_kind_type;

   typedef struct packed {
      step_kind_type      kind;
      logic [COLOR_W-1:0] value;
      logic [INDEX_W-1:0] entry;
      match_type          known;
   } step_type;

   localparam match_type NO_MATCH    = '0;
   localparam match_type EMPTY_MATCH = '{DEFAULT_COLOR, 8'd0, 10'd0, 1'b1};

   localparam step_type DIRECTED_STEPS [0:20] = '{
      '{STEP_MAP_KNOWN, 32'h0000_0000, 8'h00, EMPTY_MATCH},
      '{STEP_MAP_KNOWN, 32'hffff_ffff, 8'hff, EMPTY_MATCH},
      '{STEP_LOAD,      32'h0000_0000, 8'd0,   NO_MATCH},
      '{STEP_LOAD,      32'hffff_ffff, 8'd1,   NO_MATCH},
      '{STEP_LOAD,      32'h0000_0000, 8'd2,   NO_MATCH},
      '{STEP_LOAD,      32'h1234_5678, 8'd255, NO_MATCH},
      '{STEP_COUNT,     32'd1,         8'd0,   NO_MATCH},
      '{STEP_MAP_KNOWN, 32'hffff_ffff, 8'h00, '{32'h0000_0000, 8'd0, 10'd1020, 1'b0}},
      '{STEP_MAP_KNOWN, 32'h0000_0000, 8'h00, '{32'h0000_0000, 8'd0, 10'd0, 1'b0}},
      '{STEP_COUNT,     32'd2,         8'd0,   NO_MATCH},
      '{STEP_MAP_KNOWN, 32'hffff_ffff, 8'h00, '{32'hffff_ffff, 8'd1, 10'd0, 1'b0}},
      '{STEP_MAP,       32'h8080_8080, 8'h00, NO_MATCH},
      '{STEP_MAP,       32'h7f7f_7f7f, 8'h00, NO_MATCH},
      // equal distance to both entries: lowest index wins
      '{STEP_MAP_KNOWN, 32'h00ff_00ff, 8'h00, '{32'h0000_0000, 8'd0, 10'd510, 1'b0}},
      '{STEP_COUNT,     32'd3,         8'd0,   NO_MATCH},
      '{STEP_MAP_KNOWN, 32'h0000_0001, 8'h00, '{32'h0000_0000, 8'd0, 10'd1, 1'b0}},
      '{STEP_LOAD,      32'ha5a5_a5a5, 8'd0,   NO_MATCH},
      '{STEP_MAP,       32'h0000_0001, 8'h00, NO_MATCH},
      '{STEP_MAP,       32'ha5a5_a5a5, 8'h00, NO_MATCH},
      '{STEP_COUNT,     32'd0,         8'd0,   NO_MATCH},
      '{STEP_MAP_KNOWN, 32'h5a5a_5a5a, 8'h5a, EMPTY_MATCH}
   };

   localparam int PHASE_COUNTS [0:7] = '{1, 4, 16, COUNT_MAX, SEARCH_SPAN, 0, SEARCH_SPAN - 1, 2};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_func = FUNC_LOAD;
   logic [INDEX_W-1:0] req_entry_index = '0;
   logic [COLOR_W-1:0] req_color_word = '0;
   logic               rsp_strobe;
   logic [COLOR_W-1:0] rsp_mapped_color;
   logic [INDEX_W-1:0] rsp_best_index;
   logic [DIST_W-1:0]  rsp_best_distance;
   logic               rsp_no_entry;
   logic               csr_write_en = 1'b0;
   logic [COUNT_W-1:0] csr_write_data = '0;

   logic [COLOR_W-1:0] palette_shadow [PALETTE_DEPTH_DEFAULT];
   bit                 written_mask [PALETTE_DEPTH_DEFAULT];
   logic [COUNT_W-1:0] count_shadow = '0;
   match_type          pending_maps [$];
   int                 errors = 0;
   int                 idle_run = 0;
   int                 burst_left = 0;

   nearest_palette_color_l1 dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_entry_index   (req_entry_index),
      .req_color_word    (req_color_word),
      .rsp_strobe        (rsp_strobe),
      .rsp_mapped_color  (rsp_mapped_color),
      .rsp_best_index    (rsp_best_index),
      .rsp_best_distance (rsp_best_distance),
      .rsp_no_entry      (rsp_no_entry),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic int searched_entries();
      return (int'(count_shadow) > SEARCH_SPAN) ? SEARCH_SPAN : int'(count_shadow);
   endfunction

   // Sequential search over the shadow palette; strict less-than keeps the lowest index.
   function automatic match_type nearest_entry(logic [COLOR_W-1:0] pixel);
      match_type best;
      int        best_gap;
      int        gap;
      int        diff;
      best     = EMPTY_MATCH;
      best_gap = int'(NO_DISTANCE);
      for (int k = 0; k < searched_entries(); k++) begin
         gap = 0;
         for (int b = 0; b < 4; b++) begin
            diff = int'(pixel[8*b +: 8]) - int'(palette_shadow[k][8*b +: 8]);
            gap += (diff < 0) ? -diff : diff;
         end
         if (gap < best_gap) begin
            best_gap      = gap;
            best.color    = palette_shadow[k];
            best.index    = INDEX_W'(k);
            best.distance = DIST_W'(gap);
            best.no_entry = 1'b0;
         end
      end
      return best;
   endfunction

   // Lowest entry in the searched range that was never loaded, or -1.
   function automatic int first_hole();
      for (int k = 0; k < searched_entries(); k++)
         if (!written_mask[k]) return k;
      return -1;
   endfunction

   function automatic logic [COLOR_W-1:0] extreme_bytes();
      logic [COLOR_W-1:0] word;
      for (int b = 0; b < 4; b++)
         word[8*b +: 8] = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
      return word;
   endfunction

   function automatic logic [COLOR_W-1:0] pixel_for(int active);
      int mode;
      mode = $urandom_range(0, 9);
      if (active > 0 && mode inside {[4:5]})
         return palette_shadow[$urandom_range(0, active - 1)];
      if (active > 0 && mode inside {[6:7]})
         return palette_shadow[$urandom_range(0, active - 1)] ^ ($urandom() & 32'h0707_0707);
      if (mode == 8)
         return extreme_bytes();
      return $urandom();
   endfunction

   function automatic logic [COLOR_W-1:0] load_color_for(int active);
      int mode;
      mode = $urandom_range(0, 9);
      // duplicate colors make equal distances, so ties get exercised
      if (active > 0 && mode inside {[6:7]})
         return palette_shadow[$urandom_range(0, active - 1)];
      if (mode >= 8)
         return extreme_bytes();
      return $urandom();
   endfunction

   task automatic word_out(input logic func, input logic [INDEX_W-1:0] entry,
                           input logic [COLOR_W-1:0] color, input bit known,
                           input match_type known_result);
      start           <= 1'b1;
      req_func        <= func;
      req_entry_index <= entry;
      req_color_word  <= color;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (func == FUNC_LOAD) begin
         palette_shadow[entry] = color;
         written_mask[entry]   = 1'b1;
      end else begin
         pending_maps.push_back(known ? known_result : nearest_entry(color));
      end
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Bursts of random length; the gap is zero often enough to leave long unbroken runs.
   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         hold_off(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
      end
      burst_left--;
   endtask

   // Loads give no result, so wait out the chain after the last map returns.
   task automatic drain();
      start <= 1'b0;
      while (pending_maps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      count_shadow    = value;
   endtask

   task automatic check_field(input string name, input logic [COLOR_W-1:0] want,
                              input logic [COLOR_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      match_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_run = 0;
         else idle_run++;
         if (idle_run >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("nearest_palette_color_l1 verification failed");
            $finish;
         end
         if (rsp_strobe) begin
            if (pending_maps.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none actual %h/%h/%h/%b", $time,
                        rsp_mapped_color, rsp_best_index, rsp_best_distance, rsp_no_entry);
            end else begin
               want = pending_maps.pop_front();
               check_field("mapped_color", want.color, rsp_mapped_color);
               check_field("best_index", COLOR_W'(want.index), COLOR_W'(rsp_best_index));
               check_field("best_distance", COLOR_W'(want.distance),
                           COLOR_W'(rsp_best_distance));
               check_field("no_entry", COLOR_W'(want.no_entry), COLOR_W'(rsp_no_entry));
            end
         end
      end
   end

   initial begin
      int active;
      int hole;
      int words;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_STEPS[i]) begin
         case (DIRECTED_STEPS[i].kind)
            STEP_COUNT: begin
               write_count(DIRECTED_STEPS[i].value[COUNT_W-1:0]);
            end
            STEP_LOAD: begin
               pace();
               word_out(FUNC_LOAD, DIRECTED_STEPS[i].entry, DIRECTED_STEPS[i].value,
                        1'b0, NO_MATCH);
            end
            STEP_MAP: begin
               pace();
               word_out(FUNC_MAP, DIRECTED_STEPS[i].entry, DIRECTED_STEPS[i].value,
                        1'b0, NO_MATCH);
            end
            default: begin
               pace();
               word_out(FUNC_MAP, DIRECTED_STEPS[i].entry, DIRECTED_STEPS[i].value,
                        1'b1, DIRECTED_STEPS[i].known);
            end
         endcase
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_count((p < 8) ? COUNT_W'(PHASE_COUNTS[p]) :
                               COUNT_W'($urandom_range(0, COUNT_MAX)));
         words = 0;
         while (words < PHASE_WORDS) begin
            active = searched_entries();
            hole   = first_hole();
            pace();
            if ($urandom_range(0, 9) < 6) begin
               // never search an entry that holds nothing yet: fill it first
               if (hole >= 0) begin
                  word_out(FUNC_LOAD, INDEX_W'(hole), $urandom(), 1'b0, NO_MATCH);
               end else begin
                  words++;
                  word_out(FUNC_MAP, INDEX_W'($urandom_range(0, 255)), pixel_for(active),
                           1'b0, NO_MATCH);
               end
            end else begin
               words++;
               word_out(FUNC_LOAD,
                        (active > 0 && $urandom_range(0, 1) == 1) ?
                           INDEX_W'($urandom_range(0, active - 1)) :
                           INDEX_W'($urandom_range(0, 255)),
                        load_color_for(active), 1'b0, NO_MATCH);
            end
         end
      end

      drain();
      if (errors == 0) begin
         $display("nearest_palette_color_l1 verification clean");
      end else begin
         $display("nearest_palette_color_l1 verification failed");
      end
      $finish;
   end

endmodule
